/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the keyframe track sampler.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define KTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/kts_pkg.sv */
// Package of the keyframe track sampler: codes, types and fixed-point helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package kts_pkg;
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;

  localparam logic [1:0] KIND_VEC3 = 2'd1;
  localparam logic [1:0] KIND_QUAT = 2'd2;

  localparam logic [1:0] CFG_INTERP = 2'd0;
  localparam logic [1:0] CFG_KIND   = 2'd1;
  localparam logic [1:0] CFG_FCOUNT = 2'd2;

  localparam logic signed [31:0] ONE_Q = 32'sd65536;

  typedef logic signed [32:0] vec_t;
  typedef logic signed [33:0] mop_t;

  // Round a Q32.32 product to Q16.16, ties toward plus infinity.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

/* hdl/keyframe_track_sampler.sv */
// Keyframe track sampler top level: key stores, sequencer and shared units.
// Depends on kts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Channel  Direction  Ports                               Transfer when
// input    in         start, busy, in_*                   start high and busy low
// config   in         cfg_valid, cfg_ready, cfg_index,    cfg_valid and cfg_ready
//                     cfg_data
// result   out        out_valid, out_*                    out_valid high (one cycle)
//
// A load transfer writes the key stores at the accepting edge and leaves busy low.
// A sample's length depends on its path: a track with too few frames goes straight to
// the default result; otherwise the one-bit-per-cycle divider, the 32-step square root,
// the downward scan (S_SCAN then S_SCMP for each frame) and each quaternion
// normalization set it.
// Reset is synchronous, active low, and restores the configuration registers.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module keyframe_track_sampler
  import kts_pkg::*;
#(
  parameter int MAX_FRAMES = 64,
  parameter int COMPONENTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [5:0]         in_frame_index,
  input  logic [1:0]         in_component,
  input  logic signed [31:0] in_key_time,
  input  logic signed [31:0] in_key_value,
  input  logic signed [31:0] in_in_slope,
  input  logic signed [31:0] in_out_slope,
  input  logic signed [31:0] in_sample_time,
  input  logic               in_looping,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic               out_is_default
);
  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW    = $clog2(MAX_FRAMES + 1);
  localparam int DEPTH = MAX_FRAMES * COMPONENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DVW   = 49;

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_TEND, S_TPEN, S_SPAN, S_WRAP, S_SCAN, S_SCMP, S_FRAME,
    S_GAP0, S_GAP1, S_TFRAC, S_KF, S_KDONE, S_DOT, S_ISTART, S_LIN, S_TT,
    S_TT2, S_TTT, S_TTT2, S_HSET, S_HERM, S_POST, S_QMAG, S_QSQ, S_QSQRT,
    S_QDIV, S_QDIVR, S_DIV, S_OUT, S_DEF
  } state_t;

  // Key stores. They hold no reset value; unwritten entries are never read
  // by a legal sample.
  logic signed [31:0] kt_mem [MAX_FRAMES];
  logic signed [31:0] kv_mem [DEPTH];
  logic signed [31:0] ki_mem [DEPTH];
  logic signed [31:0] ko_mem [DEPTH];
  logic signed [31:0] kt_rd_r, kv_rd_r, ki_rd_r, ko_rd_r;
  logic [FW-1:0]      kt_ra;
  logic [AW-1:0]      kv_ra, ki_ra, ko_ra, wr_a;

  state_t state_r, qret_r, dret_r;
  logic [1:0] mode_r, kind_r;
  logic [6:0] fcnt_r;

  logic signed [31:0] time_r, t0_r, tend_r, track_r, ktf_r;
  logic signed [32:0] dur_r, gap_r;
  logic               loop_r, quat_r, ksel_r, qsh;
  logic [CW-1:0]      count_r, cnt_w;
  logic [2:0]         n_r, kcnt_r, st_r;
  logic [1:0]         cc_r, qi_r;
  logic [FW-1:0]      idx_r, fr_r, kfr;
  logic [16:0]        tq_r, tt_r, ttt_r;
  logic signed [19:0] h1_r, h2_r, h3_r, h4_r;
  logic signed [31:0] tno_r, tni_r, s1_r, s2_r;
  vec_t               q_r [4];
  vec_t               a_r [4];
  vec_t               b_r [4];
  vec_t               qmag [4];
  logic [31:0]        qm_r [4];
  logic signed [53:0] acc_r;
  logic signed [53:0] acc_sum;
  logic [63:0]        qs_r, sq_s_r, sq_r_r, sq_b_r, sq_t, sq_rn;
  logic [32:0]        len_r;
  logic               sq_ge;

  // Shared multiplier with a registered product.
  mop_t               mul_a, mul_b;
  logic signed [67:0] prod_full;
  logic signed [63:0] prod_r;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DVW-1:0] dv_q_r;
  logic [33:0]    dv_rem_r, dv_rem2;
  logic [32:0]    dv_d_r;
  logic [5:0]     dv_cnt_r;
  logic           dv_ge;

  logic signed [32:0] dur_w, d_w, gap_w, num_w;
  logic [32:0]        d_mag, wrap_m;
  logic               accept;

  function automatic logic [AW-1:0] caddr(input logic [FW-1:0] f, input logic [1:0] c);
    int csel;
    csel = (int'(c) < COMPONENTS) ? int'(c) : 0;
    return AW'(int'(f) * COMPONENTS + csel);
  endfunction

  function automatic logic cvalid(input logic [1:0] c, input logic [2:0] n);
    return (3'(c) < n) && (int'(c) < COMPONENTS);
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cnt_w     = (32'(fcnt_r) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(fcnt_r);
  assign kfr       = ksel_r ? fr_r + FW'(1) : fr_r;
  assign wr_a      = caddr(FW'(in_frame_index), in_component);

  assign dur_w  = 33'(tend_r) - 33'(t0_r);
  assign d_w    = 33'(time_r) - 33'(t0_r);
  assign d_mag  = d_w[32] ? 33'(-d_w) : 33'(d_w);
  assign wrap_m = (d_w[32] && (dv_rem_r[32:0] != '0)) ? 33'(dur_r) - dv_rem_r[32:0]
                                                       : dv_rem_r[32:0];
  assign gap_w  = 33'(kt_rd_r) - 33'(ktf_r);
  assign num_w  = 33'(track_r) - 33'(ktf_r);

  assign dv_rem2 = {dv_rem_r[32:0], dv_q_r[DVW-1]};
  assign dv_ge   = dv_rem2 >= {1'b0, dv_d_r};

  assign sq_t  = sq_r_r + sq_b_r;
  assign sq_ge = sq_s_r >= sq_t;
  assign sq_rn = sq_ge ? (sq_r_r >> 1) + sq_b_r : (sq_r_r >> 1);

  assign acc_sum   = acc_r + 54'(prod_r);
  assign prod_full = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmag[i] = q_r[i][32] ? -q_r[i] : q_r[i];
    end
    qsh = qmag[0][31] | qmag[1][31] | qmag[2][31] | qmag[3][31];
  end

  // Read addresses and multiplier operands follow the sequencer state.
  always_comb begin
    kt_ra = '0;
    kv_ra = '0;
    ki_ra = '0;
    ko_ra = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TEND:  kt_ra = FW'(count_r - CW'(1));
      S_TPEN:  kt_ra = FW'(count_r - CW'(2));
      S_SCAN:  kt_ra = idx_r;
      S_FRAME: kt_ra = fr_r;
      S_GAP0:  kt_ra = fr_r + FW'(1);
      S_KF:    kv_ra = caddr(kfr, kcnt_r[1:0]);
      S_DOT: begin
        mul_a = 34'(a_r[kcnt_r[1:0]]);
        mul_b = 34'(b_r[kcnt_r[1:0]]);
      end
      S_QSQ: begin
        mul_a = {2'b0, qm_r[kcnt_r[1:0]]};
        mul_b = {2'b0, qm_r[kcnt_r[1:0]]};
      end
      S_LIN: begin
        mul_a = 34'(b_r[cc_r]) - 34'(a_r[cc_r]);
        mul_b = {17'b0, tq_r};
      end
      S_TT: begin
        mul_a = {17'b0, tq_r};
        mul_b = {17'b0, tq_r};
      end
      S_TTT: begin
        mul_a = {17'b0, tt_r};
        mul_b = {17'b0, tq_r};
      end
      S_HERM: begin
        ko_ra = caddr(fr_r, cc_r);
        ki_ra = caddr(fr_r + FW'(1), cc_r);
        case (st_r)
          3'd0: begin
            mul_a = 34'(a_r[cc_r]);
            mul_b = 34'(h1_r);
          end
          3'd1: begin
            mul_a = 34'(b_r[cc_r]);
            mul_b = 34'(h2_r);
          end
          3'd2: begin
            mul_a = 34'(tno_r);
            mul_b = 34'(gap_r);
          end
          3'd3: begin
            mul_a = 34'(tni_r);
            mul_b = 34'(gap_r);
          end
          3'd4: begin
            mul_a = 34'(s1_r);
            mul_b = 34'(h3_r);
          end
          3'd5: begin
            mul_a = 34'(s2_r);
            mul_b = 34'(h4_r);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Key stores: written by load transfers, read with registered data.
  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_LOAD) && (32'(in_frame_index) < MAX_FRAMES) &&
        (int'(in_component) < COMPONENTS)) begin
      kt_mem[FW'(in_frame_index)] <= in_key_time;
      kv_mem[wr_a] <= in_key_value;
      ki_mem[wr_a] <= in_in_slope;
      ko_mem[wr_a] <= in_out_slope;
    end
    kt_rd_r <= kt_mem[kt_ra];
    kv_rd_r <= kv_mem[kv_ra];
    ki_rd_r <= ki_mem[ki_ra];
    ko_rd_r <= ko_mem[ko_ra];
    prod_r  <= prod_full[63:0];
  end

  // Sequencer, configuration registers and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      qret_r    <= S_IDLE;
      dret_r    <= S_IDLE;
      mode_r    <= MODE_LINEAR;
      kind_r    <= 2'd0;
      fcnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERP: mode_r <= cfg_data[1:0];
          CFG_KIND:   kind_r <= cfg_data[1:0];
          CFG_FCOUNT: fcnt_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_opcode == OP_SAMPLE)) begin
            time_r  <= in_sample_time;
            loop_r  <= in_looping;
            count_r <= cnt_w;
            quat_r  <= (kind_r == KIND_QUAT);
            n_r     <= (kind_r == KIND_VEC3) ? 3'd3 : ((kind_r == KIND_QUAT) ? 3'd4 : 3'd1);
            track_r <= '0;
            state_r <= (cnt_w < CW'(2)) ? S_DEF : S_T0;
          end
        end
        S_T0: state_r <= S_TEND;
        S_TEND: begin
          t0_r    <= kt_rd_r;
          state_r <= S_TPEN;
        end
        S_TPEN: begin
          tend_r  <= kt_rd_r;
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          dur_r <= dur_w;
          if (loop_r) begin
            if (dur_w <= 33'sd0) begin
              state_r <= S_DEF;
            end else begin
              dv_q_r   <= DVW'(d_mag);
              dv_d_r   <= dur_w;
              dv_rem_r <= '0;
              dv_cnt_r <= '0;
              dret_r   <= S_WRAP;
              state_r  <= S_DIV;
            end
          end else begin
            if (dur_w > 33'sd0) begin
              track_r <= (time_r <= t0_r) ? t0_r : ((time_r >= tend_r) ? tend_r : time_r);
            end
            if (time_r <= t0_r) begin
              fr_r    <= '0;
              state_r <= S_FRAME;
            end else if (time_r >= kt_rd_r) begin
              fr_r    <= FW'(count_r - CW'(2));
              state_r <= S_FRAME;
            end else begin
              idx_r   <= FW'(count_r - CW'(1));
              state_r <= S_SCAN;
            end
          end
        end
        S_WRAP: begin
          // The remainder takes the sign of the offset; fold it into the span.
          time_r  <= 32'(33'(t0_r) + $signed(wrap_m));
          track_r <= 32'(33'(t0_r) + $signed(wrap_m));
          idx_r   <= FW'(count_r - CW'(1));
          state_r <= S_SCAN;
        end
        S_SCAN: state_r <= S_SCMP;
        S_SCMP: begin
          if (time_r >= kt_rd_r) begin
            fr_r    <= idx_r;
            state_r <= S_FRAME;
          end else if (idx_r == '0) begin
            state_r <= S_DEF;
          end else begin
            idx_r   <= idx_r - FW'(1);
            state_r <= S_SCAN;
          end
        end
        S_FRAME: begin
          if (mode_r == MODE_CONST) begin
            ksel_r  <= 1'b0;
            kcnt_r  <= '0;
            state_r <= S_KF;
          end else if ((CW'(fr_r) + CW'(1)) >= count_r) begin
            state_r <= S_DEF;
          end else begin
            state_r <= S_GAP0;
          end
        end
        S_GAP0: begin
          ktf_r   <= kt_rd_r;
          state_r <= S_GAP1;
        end
        S_GAP1: begin
          gap_r <= gap_w;
          if (gap_w <= 33'sd0) begin
            state_r <= S_DEF;
          end else if (num_w <= 33'sd0) begin
            tq_r    <= '0;
            ksel_r  <= 1'b0;
            kcnt_r  <= '0;
            state_r <= S_KF;
          end else begin
            dv_q_r   <= DVW'({num_w[31:0], 16'b0});
            dv_d_r   <= gap_w;
            dv_rem_r <= '0;
            dv_cnt_r <= '0;
            dret_r   <= S_TFRAC;
            state_r  <= S_DIV;
          end
        end
        S_TFRAC: begin
          tq_r    <= (dv_q_r > DVW'(65536)) ? 17'd65536 : dv_q_r[16:0];
          ksel_r  <= 1'b0;
          kcnt_r  <= '0;
          state_r <= S_KF;
        end
        S_KF: begin
          if (kcnt_r != 3'd0) begin
            q_r[2'(kcnt_r - 3'd1)] <= cvalid(2'(kcnt_r - 3'd1), n_r) ? 33'(kv_rd_r) : '0;
          end
          if (kcnt_r == 3'd4) begin
            qret_r  <= S_KDONE;
            state_r <= quat_r ? S_QMAG : S_KDONE;
          end else begin
            kcnt_r <= kcnt_r + 3'd1;
          end
        end
        S_KDONE: begin
          if (!ksel_r) begin
            a_r <= q_r;
            if (mode_r == MODE_CONST) begin
              state_r <= S_OUT;
            end else begin
              ksel_r  <= 1'b1;
              kcnt_r  <= '0;
              state_r <= S_KF;
            end
          end else begin
            b_r <= q_r;
            kcnt_r  <= '0;
            acc_r   <= '0;
            state_r <= quat_r ? S_DOT : S_ISTART;
          end
        end
        S_DOT: begin
          if (kcnt_r != 3'd0) acc_r <= acc_sum;
          if (kcnt_r == 3'd4) begin
            // Far key goes into the near key's hemisphere.
            if (acc_sum < 54'sd0) begin
              for (int i = 0; i < 4; i++) b_r[i] <= -b_r[i];
            end
            state_r <= S_ISTART;
          end else begin
            kcnt_r <= kcnt_r + 3'd1;
          end
        end
        S_ISTART: begin
          st_r    <= '0;
          cc_r    <= '0;
          state_r <= (mode_r == MODE_LINEAR) ? S_LIN : S_TT;
        end
        S_LIN: begin
          if (st_r == 3'd0) begin
            st_r <= 3'd1;
          end else begin
            q_r[cc_r] <= 33'(sat32(64'(a_r[cc_r]) + rnd16(prod_r)));
            st_r      <= '0;
            cc_r      <= cc_r + 2'd1;
            if (cc_r == 2'd3) state_r <= S_POST;
          end
        end
        S_TT:  state_r <= S_TT2;
        S_TT2: begin
          tt_r    <= rnd16(prod_r)[16:0];
          state_r <= S_TTT;
        end
        S_TTT: state_r <= S_TTT2;
        S_TTT2: begin
          ttt_r   <= rnd16(prod_r)[16:0];
          state_r <= S_HSET;
        end
        S_HSET: begin
          h1_r    <= 20'sd2 * $signed({3'b0, ttt_r}) - 20'sd3 * $signed({3'b0, tt_r}) +
                     20'sd65536;
          h2_r    <= 20'sd3 * $signed({3'b0, tt_r}) - 20'sd2 * $signed({3'b0, ttt_r});
          h3_r    <= $signed({3'b0, ttt_r}) - 20'sd2 * $signed({3'b0, tt_r}) +
                     $signed({3'b0, tq_r});
          h4_r    <= $signed({3'b0, ttt_r}) - $signed({3'b0, tt_r});
          st_r    <= '0;
          cc_r    <= '0;
          state_r <= S_HERM;
        end
        S_HERM: begin
          st_r <= st_r + 3'd1;
          case (st_r)
            3'd1: begin
              acc_r <= 54'(prod_r);
              tno_r <= cvalid(cc_r, n_r) ? ko_rd_r : '0;
              tni_r <= cvalid(cc_r, n_r) ? ki_rd_r : '0;
            end
            3'd2: acc_r <= acc_sum;
            3'd3: s1_r <= sat32(rnd16(prod_r));
            3'd4: s2_r <= sat32(rnd16(prod_r));
            3'd5: acc_r <= acc_sum;
            3'd6: begin
              q_r[cc_r] <= 33'(sat32(rnd16(64'(acc_r) + prod_r)));
              st_r      <= '0;
              cc_r      <= cc_r + 2'd1;
              if (cc_r == 2'd3) state_r <= S_POST;
            end
            default: ;
          endcase
        end
        S_POST: begin
          qret_r  <= S_OUT;
          state_r <= quat_r ? S_QMAG : S_OUT;
        end
        S_QMAG: begin
          // A magnitude of 2^31 halves all four so the squares fit.
          for (int i = 0; i < 4; i++) begin
            qm_r[i] <= qsh ? qmag[i][32:1] : qmag[i][31:0];
          end
          qs_r    <= '0;
          kcnt_r  <= '0;
          state_r <= S_QSQ;
        end
        S_QSQ: begin
          if (kcnt_r != 3'd0) qs_r <= qs_r + prod_r;
          if (kcnt_r == 3'd4) begin
            sq_s_r  <= qs_r + prod_r;
            sq_r_r  <= '0;
            sq_b_r  <= 64'd1 << 62;
            state_r <= S_QSQRT;
          end else begin
            kcnt_r <= kcnt_r + 3'd1;
          end
        end
        S_QSQRT: begin
          if (sq_ge) sq_s_r <= sq_s_r - sq_t;
          sq_r_r <= sq_rn;
          sq_b_r <= sq_b_r >> 2;
          if (sq_b_r == 64'd1) begin
            len_r   <= sq_rn[32:0];
            qi_r    <= '0;
            state_r <= (sq_rn == '0) ? qret_r : S_QDIV;
          end
        end
        S_QDIV: begin
          dv_q_r   <= DVW'({qm_r[qi_r], 16'b0});
          dv_d_r   <= len_r;
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
          dret_r   <= S_QDIVR;
          state_r  <= S_DIV;
        end
        S_QDIVR: begin
          q_r[qi_r] <= q_r[qi_r][32] ? -33'(dv_q_r[17:0]) : 33'(dv_q_r[17:0]);
          qi_r      <= qi_r + 2'd1;
          state_r   <= (qi_r == 2'd3) ? qret_r : S_QDIV;
        end
        S_DIV: begin
          dv_rem_r <= dv_ge ? dv_rem2 - {1'b0, dv_d_r} : dv_rem2;
          dv_q_r   <= {dv_q_r[DVW-2:0], dv_ge};
          dv_cnt_r <= dv_cnt_r + 6'd1;
          if (dv_cnt_r == 6'(DVW - 1)) state_r <= dret_r;
        end
        S_OUT: begin
          out_valid      <= 1'b1;
          out_x          <= q_r[0][31:0];
          out_y          <= (n_r >= 3'd3) ? q_r[1][31:0] : '0;
          out_z          <= (n_r >= 3'd3) ? q_r[2][31:0] : '0;
          out_w          <= (n_r == 3'd4) ? q_r[3][31:0] : '0;
          out_is_default <= 1'b0;
          state_r        <= S_IDLE;
        end
        S_DEF: begin
          out_valid      <= 1'b1;
          out_x          <= '0;
          out_y          <= '0;
          out_z          <= '0;
          out_w          <= quat_r ? ONE_Q : '0;
          out_is_default <= 1'b1;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `KTS_ASSERT_NOW(a_out_after_work, out_valid, !busy && $past(busy), "result without a sample")
  `KTS_ASSERT_NEXT(a_load_no_busy, accept && (in_opcode == OP_LOAD), !busy, "load held the block")
  `KTS_ASSERT_NEXT(a_sample_busy, accept && (in_opcode == OP_SAMPLE), busy, "sample not started")
  `KTS_ASSERT_NOW(a_default_val, out_valid && out_is_default,
                  out_x == '0 && out_y == '0 && out_z == '0 &&
                  out_w == (quat_r ? ONE_Q : '0), "bad default value")
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the keyframe track sampler.
// Depends on kts_pkg and on the keyframe_track_sampler top level.
`timescale 1ns / 1ps

module testbench;
  import kts_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] MODE_CUBIC   = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // Idle waits use a safe margin over the longest sample.
  localparam int DRAIN_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef logic signed [127:0] wide_t;
  typedef wide_t quad_t[4];

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               dflt;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = OP_LOAD;
  logic [5:0] in_frame_index = '0;
  logic [1:0] in_component = '0;
  logic signed [31:0] in_key_time = '0;
  logic signed [31:0] in_key_value = '0;
  logic signed [31:0] in_in_slope = '0;
  logic signed [31:0] in_out_slope = '0;
  logic signed [31:0] in_sample_time = '0;
  logic in_looping = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_INTERP;
  logic [6:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic out_is_default;

  // Shadow copy of the key stores and registers, updated at each load and register write.
  logic signed [31:0] shadow_time[64];
  logic signed [31:0] shadow_value[256];
  logic signed [31:0] shadow_in_tan[256];
  logic signed [31:0] shadow_out_tan[256];
  logic [1:0] shadow_mode;
  logic [1:0] shadow_kind;
  logic [6:0] shadow_count;

  sample_t pending_samples[$];
  int error_count = 0;
  int sample_count = 0;
  int load_count = 0;
  int default_count = 0;
  longint cycle_count = 0;
  bit no_idle = 1'b0;

  always #1 clk = ~clk;

  keyframe_track_sampler dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Fixed-point helpers used by the predictor.
  function automatic wide_t round_q(input wide_t v);
    return (v + wide_t'(32768)) >>> 16;
  endfunction

  function automatic wide_t clamp32(input wide_t v);
    if (v > wide_t'(64'sd2147483647)) return wide_t'(64'sd2147483647);
    if (v < -wide_t'(64'sd2147483648)) return -wide_t'(64'sd2147483648);
    return v;
  endfunction

  function automatic wide_t floor_sqrt(input wide_t s);
    wide_t r;
    wide_t b;
    r = 0;
    b = wide_t'(1) <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Scale a quaternion to unit length; a zero quaternion stays as it is.
  function automatic quad_t normalize(input quad_t q);
    wide_t mag[4];
    wide_t sum;
    wide_t len;
    quad_t r;
    bit halve;
    halve = 1'b0;
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      mag[c] = q[c] < 0 ? -q[c] : q[c];
      if (mag[c] > wide_t'(32'h7fffffff)) halve = 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      if (halve) mag[c] = mag[c] >>> 1;
      sum = sum + mag[c] * mag[c];
    end
    len = floor_sqrt(sum);
    r = q;
    if (len != 0) begin
      for (int c = 0; c < 4; c++) begin
        r[c] = (mag[c] <<< 16) / len;
        if (q[c] < 0) r[c] = -r[c];
      end
    end
    return r;
  endfunction

  function automatic int used_components();
    if (shadow_kind == KIND_VEC3) return 3;
    if (shadow_kind == KIND_QUAT) return 4;
    return 1;
  endfunction

  function automatic quad_t key_at(input int f);
    quad_t v;
    int n;
    n = used_components();
    for (int c = 0; c < 4; c++) v[c] = (c < n) ? wide_t'(shadow_value[f * 4 + c]) : 0;
    if (shadow_kind == KIND_QUAT) v = normalize(v);
    return v;
  endfunction

  // Expected result of a sample transfer at the current register settings.
  function automatic sample_t predict_sample(input logic signed [31:0] when, input logic loop);
    sample_t r;
    quad_t res, ka, kb;
    wide_t tm, first, last, span, md, track_t, gap, num, t, t2, t3;
    wide_t h1, h2, h3, h4, s1, s2, acc;
    int count, n, fr;
    bit quat, found;
    count = shadow_count > 64 ? 64 : shadow_count;
    quat = (shadow_kind == KIND_QUAT);
    n = used_components();
    tm = wide_t'(when);
    track_t = 0;
    found = 1'b0;
    fr = 0;
    for (int c = 0; c < 4; c++) res[c] = 0;
    if (count >= 2) begin
      first = wide_t'(shadow_time[0]);
      last = wide_t'(shadow_time[count - 1]);
      span = last - first;
      if (loop) begin
        if (span > 0) begin
          md = (tm - first) % span;
          if (md < 0) md = md + span;
          tm = first + md;
          track_t = tm;
          for (int i = count - 1; i >= 0; i--) begin
            if (tm >= wide_t'(shadow_time[i])) begin
              fr = i;
              found = 1'b1;
              break;
            end
          end
        end
      end else begin
        if (span > 0) track_t = tm <= first ? first : (tm >= last ? last : tm);
        if (tm <= first) begin
          fr = 0;
          found = 1'b1;
        end else if (tm >= wide_t'(shadow_time[count - 2])) begin
          fr = count - 2;
          found = 1'b1;
        end else begin
          for (int i = count - 1; i >= 0; i--) begin
            if (tm >= wide_t'(shadow_time[i])) begin
              fr = i;
              found = 1'b1;
              break;
            end
          end
        end
      end
    end

    if (found && shadow_mode == MODE_CONST) begin
      res = key_at(fr);
    end else if (found && fr < count - 1) begin
      gap = wide_t'(shadow_time[fr + 1]) - wide_t'(shadow_time[fr]);
      if (gap <= 0) begin
        found = 1'b0;
      end else begin
        num = track_t - wide_t'(shadow_time[fr]);
        t = num <= 0 ? 0 : (num * 65536) / gap;
        if (t > 65536) t = 65536;
        ka = key_at(fr);
        kb = key_at(fr + 1);
        // Take the shorter arc between the two quaternion keys.
        if (quat && (ka[0] * kb[0] + ka[1] * kb[1] + ka[2] * kb[2] + ka[3] * kb[3]) < 0) begin
          for (int c = 0; c < 4; c++) kb[c] = -kb[c];
        end
        if (shadow_mode == MODE_LINEAR) begin
          for (int c = 0; c < 4; c++) res[c] = clamp32(ka[c] + round_q((kb[c] - ka[c]) * t));
        end else begin
          t2 = round_q(t * t);
          t3 = round_q(t2 * t);
          h1 = 2 * t3 - 3 * t2 + 65536;
          h2 = -2 * t3 + 3 * t2;
          h3 = t3 - 2 * t2 + t;
          h4 = t3 - t2;
          for (int c = 0; c < 4; c++) begin
            s1 = (c < n) ? clamp32(round_q(wide_t'(shadow_out_tan[fr * 4 + c]) * gap)) : 0;
            s2 = (c < n) ? clamp32(round_q(wide_t'(shadow_in_tan[(fr + 1) * 4 + c]) * gap)) : 0;
            acc = ka[c] * h1 + kb[c] * h2 + s1 * h3 + s2 * h4;
            res[c] = clamp32(round_q(acc));
          end
        end
        if (quat) res = normalize(res);
      end
    end else begin
      found = 1'b0;
    end

    if (!found) begin
      for (int c = 0; c < 3; c++) res[c] = 0;
      res[3] = quat ? 65536 : 0;
    end
    r.x = res[0][31:0];
    r.y = (n > 1) ? res[1][31:0] : 32'sd0;
    r.z = (n > 2) ? res[2][31:0] : 32'sd0;
    r.w = (n > 3 || !found) ? res[3][31:0] : 32'sd0;
    r.dflt = !found;
    return r;
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        $error("result strobe with no sample outstanding");
        error_count++;
      end else begin
        exp_s = pending_samples.pop_front();
        if (out_x !== exp_s.x) begin
          $error("out_x expected %h actual %h", exp_s.x, out_x);
          error_count++;
        end
        if (out_y !== exp_s.y) begin
          $error("out_y expected %h actual %h", exp_s.y, out_y);
          error_count++;
        end
        if (out_z !== exp_s.z) begin
          $error("out_z expected %h actual %h", exp_s.z, out_z);
          error_count++;
        end
        if (out_w !== exp_s.w) begin
          $error("out_w expected %h actual %h", exp_s.w, out_w);
          error_count++;
        end
        if (out_is_default !== exp_s.dflt) begin
          $error("is_default expected %b actual %b", exp_s.dflt, out_is_default);
          error_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one item and hold start until the block takes it.
  task automatic send_item(input logic op, input logic [5:0] fi, input logic [1:0] comp,
                           input logic signed [31:0] kt, input logic signed [31:0] kv,
                           input logic signed [31:0] isl, input logic signed [31:0] osl,
                           input logic signed [31:0] st, input logic lp);
    int gap;
    int idx;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_opcode = op;
    in_frame_index = fi;
    in_component = comp;
    in_key_time = kt;
    in_key_value = kv;
    in_in_slope = isl;
    in_out_slope = osl;
    in_sample_time = st;
    in_looping = lp;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      idx = fi * 4 + comp;
      shadow_time[fi] = kt;
      shadow_value[idx] = kv;
      shadow_in_tan[idx] = isl;
      shadow_out_tan[idx] = osl;
      load_count++;
    end else begin
      pending_samples.push_back(predict_sample(st, lp));
      sample_count++;
      if (pending_samples[$].dflt) default_count++;
    end
  endtask

  task automatic load_key(input int f, input int c, input logic signed [31:0] kt,
                          input logic signed [31:0] kv, input logic signed [31:0] isl,
                          input logic signed [31:0] osl);
    send_item(OP_LOAD, f[5:0], c[1:0], kt, kv, isl, osl, $urandom, $urandom_range(0, 1));
  endtask

  task automatic sample_at(input logic signed [31:0] st, input logic lp);
    send_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, st, lp);
  endtask

  // Stop driving, let all samples come back, then allow for the longest latency.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INTERP: shadow_mode = val[1:0];
      CFG_KIND:   shadow_kind = val[1:0];
      CFG_FCOUNT: shadow_count = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [1:0] kind, input logic [6:0] cnt);
    drain();
    write_reg(CFG_INTERP, {5'd0, mode});
    write_reg(CFG_KIND, {5'd0, kind});
    write_reg(CFG_FCOUNT, cnt);
  endtask

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
    if (r < 9) return $urandom;
    return r[0] ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  // Write frames 0..cnt-1 in all four components with time-ordered keys.
  task automatic build_track(input int cnt, input int style);
    logic signed [31:0] times[64];
    logic signed [31:0] tmp;
    int step;
    times[0] = $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
    step = $urandom_range(1, 4 * 65536);
    for (int f = 1; f < cnt; f++) begin
      case (style)
        1: times[f] = $urandom;
        2: times[f] = ($urandom_range(0, 3) == 0) ? times[f - 1] : times[f - 1] + step;
        default: times[f] = times[f - 1] + $urandom_range(1, step);
      endcase
    end
    if (style == 1) begin
      times[0] = $urandom;
      for (int i = 0; i < cnt; i++)
        for (int j = 0; j + 1 < cnt - i; j++)
          if (times[j] > times[j + 1]) begin
            tmp = times[j];
            times[j] = times[j + 1];
            times[j + 1] = tmp;
          end
    end
    for (int f = 0; f < cnt; f++)
      for (int c = 0; c < 4; c++)
        load_key(f, c, times[f], rand_value(), rand_value(), rand_value());
  endtask

  // Sample time near the current span, sometimes anywhere.
  function automatic logic signed [31:0] rand_time();
    int cnt;
    logic signed [63:0] lo, hi, span;
    cnt = shadow_count > 64 ? 64 : (shadow_count < 2 ? 2 : shadow_count);
    lo = shadow_time[0];
    hi = shadow_time[cnt - 1];
    span = hi - lo;
    if ($urandom_range(0, 9) < 2 || span <= 0 || span > 64'sd1073741824) return $urandom;
    return lo - span / 4 + $urandom_range(0, span[31:0] + span[31:0] / 2);
  endfunction

  task automatic test_reset_defaults();
    // Registers at reset: linear, scalar, no frames in use.
    sample_at(32'sd0, 1'b0);
    sample_at(32'sh7fffffff, 1'b1);
  endtask

  task automatic fill_all_frames();
    // Every slot is written once so that no sample can reach an unwritten entry.
    for (int f = 0; f < 64; f++)
      for (int c = 0; c < 4; c++)
        load_key(f, c, f * 32'sd65536, rand_value(), rand_value(), rand_value());
  endtask

  task automatic test_directed();
    // One frame in use: too few frames for any pair.
    configure(MODE_LINEAR, KIND_QUAT, 7'd1);
    sample_at(32'sd100, 1'b0);
    // Field extremes in a two-frame track, then each mode and kind.
    configure(MODE_CUBIC, KIND_VEC3, 7'd2);
    load_key(0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    load_key(1, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    sample_at(32'sh80000000, 1'b0);
    sample_at(32'sh7fffffff, 1'b1);
    sample_at(32'sd0, 1'b0);
    // Full 64-frame track from the fill, above the frame limit as well.
    configure(MODE_UNUSED, KIND_UNUSED, 7'd127);
    sample_at(32'sd10 * 32'sd65536 + 32'sd1234, 1'b0);
    sample_at(32'sd100 * 32'sd65536, 1'b1);
    configure(MODE_CONST, KIND_QUAT, 7'd64);
    sample_at(32'sd5 * 32'sd65536, 1'b0);
    sample_at(-32'sd5, 1'b1);
    // Zero gap between two frames, and a zero quaternion key.
    configure(MODE_LINEAR, KIND_QUAT, 7'd3);
    for (int c = 0; c < 4; c++) load_key(0, c, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    for (int c = 0; c < 4; c++) load_key(1, c, 32'sd0, 32'sd65536, 32'sd0, 32'sd0);
    sample_at(32'sd0, 1'b0);
    // Empty span: last time not above the first.
    for (int c = 0; c < 4; c++) load_key(2, c, -32'sd10, 32'sd65536, 32'sd0, 32'sd0);
    sample_at(32'sd3, 1'b1);
    sample_at(32'sd3, 1'b0);
  endtask

  task automatic test_random_phases();
    int cnt, r, rand_items;
    rand_items = 0;
    while (rand_items < 550) begin
      r = $urandom_range(0, 19);
      cnt = (r == 0) ? 64 : (r == 1) ? $urandom_range(0, 1) : (r == 2) ? 127
          : $urandom_range(2, 10);
      configure($urandom_range(0, 3), $urandom_range(0, 3), cnt[6:0]);
      no_idle = ($urandom_range(0, 3) == 0);
      if (cnt <= 10 && cnt >= 2) begin
        build_track(cnt, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
        rand_items += cnt * 4;
      end
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray load into the track, may break its order.
          load_key($urandom_range(0, 63), $urandom_range(0, 3), $urandom, rand_value(),
                   rand_value(), rand_value());
        end else begin
          sample_at(rand_time(), $urandom_range(0, 1));
        end
        rand_items++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    shadow_mode = MODE_LINEAR;
    shadow_kind = KIND_SCALAR;
    shadow_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    fill_all_frames();
    test_directed();
    test_random_phases();
    drain();
    $display("Covered %0d samples (%0d default) and %0d key loads", sample_count,
             default_count, load_count);
    $display("over all interpolation modes, track kinds and frame counts.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/kts_pkg.sv
hdl/keyframe_track_sampler.sv
tb/sv/testbench.sv
